>>> hw/rtl/bcc_pkg.sv
package bcc_pkg;

   // Button set and field widths
   localparam int NUM_BUTTONS = 8;
   localparam int BTN_W       = 3;
   localparam int TIMER_W     = 16;
   localparam int CNT_W       = 17;
   localparam int COUNT_CAP   = 100000;
   localparam int LEVELS_W    = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Event queue between scanner and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bus widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_FIRST_DOWN = 3'd0,
      KIND_UP         = 3'd1,
      KIND_CLICK      = 3'd2,
      KIND_LONG       = 3'd3,
      KIND_LONGLONG   = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INTERVAL = 3'd0,
      REG_LONG     = 3'd1,
      REG_LONGLONG = 3'd2,
      REG_ENABLE   = 3'd3
   } reg_index_type;

   typedef struct packed {
      logic [TIMER_W-1:0] interval_ticks;
      logic [CNT_W-1:0]   long_count;
      logic [CNT_W-1:0]   longlong_count;
      logic               events_enable;
   } cfg_type;

   typedef struct packed {
      logic [BTN_W-1:0] button;
      kind_type         kind;
      logic             last;
   } event_type;

   // Queue write side: push strobe with its word, full flag back
   typedef struct packed {
      logic      push;
      event_type word;
   } qwr_type;

endpackage

>>> hw/rtl/bcc_front.sv
module bcc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  bcc_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bcc_pkg::op_type                 req_op,
   input  logic [bcc_pkg::BTN_W-1:0]       req_id,
   input  logic [bcc_pkg::LEVELS_W-1:0]    req_levels,
   output bcc_pkg::qwr_type                qwr,
   input  logic                            q_full
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLASS,
      ST_FLUSH
   } state_type;

   state_type                       state_ff, state_in;
   logic [bcc_pkg::BTN_W-1:0]       idx_ff, idx_in;
   logic [bcc_pkg::LEVELS_W-1:0]    levels_ff, levels_in;
   bcc_pkg::kind_type               class_ff, class_in;
   logic                            pend_v_ff, pend_v_in;
   bcc_pkg::event_type              pend_ff, pend_in;

   // Per-button state, each entry read at the scan index only
   logic [bcc_pkg::TIMER_W-1:0]     timer_left_ff [bcc_pkg::NUM_BUTTONS];
   logic                            timer_run_ff  [bcc_pkg::NUM_BUTTONS];
   logic [bcc_pkg::CNT_W-1:0]       press_cnt_ff  [bcc_pkg::NUM_BUTTONS];

   logic [bcc_pkg::TIMER_W-1:0]     cur_left, left_dec, load_val;
   logic                            cur_run, expire, pressed;
   logic [bcc_pkg::CNT_W-1:0]       cur_cnt, cnt_inc;
   bcc_pkg::kind_type               rel_kind, emit_kind;
   logic                            emit_want, stall, advance, last_btn;

   logic                            wr_en, wr_run, wr_cnt_en;
   logic [bcc_pkg::BTN_W-1:0]       wr_idx;
   logic [bcc_pkg::TIMER_W-1:0]     wr_left;
   logic [bcc_pkg::CNT_W-1:0]       wr_cnt;
   logic                            take_edge;

   // Current button and derived values
   always_comb begin
      cur_left = timer_left_ff[idx_ff];
      cur_run  = timer_run_ff[idx_ff];
      cur_cnt  = press_cnt_ff[idx_ff];
      left_dec = (cur_left != '0) ? cur_left - 1'b1 : '0;
      expire   = cur_run && (left_dec == '0);
      pressed  = levels_ff[idx_ff];
      cnt_inc  = (cur_cnt < bcc_pkg::CNT_W'(bcc_pkg::COUNT_CAP)) ? cur_cnt + 1'b1 : cur_cnt;
      load_val = (cfg.interval_ticks == '0) ? bcc_pkg::TIMER_W'(1) : cfg.interval_ticks;
      last_btn = (idx_ff == bcc_pkg::BTN_W'(bcc_pkg::NUM_BUTTONS - 1));
      if (cur_cnt >= cfg.longlong_count) begin
         rel_kind = bcc_pkg::KIND_LONGLONG;
      end else if (cur_cnt >= cfg.long_count) begin
         rel_kind = bcc_pkg::KIND_LONG;
      end else begin
         rel_kind = bcc_pkg::KIND_CLICK;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign take_edge = req_valid && req_ready && (req_op == bcc_pkg::OP_EDGE)
                      && (32'(req_id) < bcc_pkg::NUM_BUTTONS);

   // Scan sequencer: one button a cycle unless stalled, plus a class state on release
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      levels_in = levels_ff;
      class_in  = class_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      emit_want = 1'b0;
      emit_kind = bcc_pkg::KIND_UP;
      advance   = 1'b0;
      wr_en     = 1'b0;
      wr_idx    = idx_ff;
      wr_left   = left_dec;
      wr_run    = cur_run;
      wr_cnt_en = 1'b0;
      wr_cnt    = cur_cnt;
      qwr.push  = 1'b0;
      qwr.word  = pend_ff;
      qwr.word.last = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take_edge) begin
               wr_en   = 1'b1;
               wr_idx  = req_id;
               wr_left = load_val;
               wr_run  = 1'b1;
            end else if (req_valid && (req_op == bcc_pkg::OP_TICK)) begin
               levels_in = req_levels;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!expire) begin
               wr_en   = cur_run;
               advance = 1'b1;
            end else if (pressed) begin
               emit_want = (cnt_inc == bcc_pkg::CNT_W'(1)) && cfg.events_enable;
               emit_kind = bcc_pkg::KIND_FIRST_DOWN;
               wr_en     = 1'b1;
               wr_left   = load_val;
               wr_run    = 1'b1;
               wr_cnt_en = 1'b1;
               wr_cnt    = cnt_inc;
               advance   = 1'b1;
            end else begin
               emit_want = cfg.events_enable;
               emit_kind = bcc_pkg::KIND_UP;
               wr_en     = 1'b1;
               wr_run    = 1'b0;
               wr_cnt_en = 1'b1;
               wr_cnt    = '0;
               class_in  = rel_kind;
               if (cfg.events_enable) begin
                  state_in = ST_CLASS;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         ST_CLASS: begin
            emit_want = 1'b1;
            emit_kind = class_ff;
            advance   = 1'b1;
         end
         ST_FLUSH: begin
            // Final held word of the tick goes out marked last
            qwr.word.last = 1'b1;
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (!q_full) begin
               qwr.push  = 1'b1;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hold everything while the queue cannot take the held word
      stall = emit_want && pend_v_ff && q_full;
      if (stall) begin
         state_in  = state_ff;
         class_in  = class_ff;
         wr_en     = 1'b0;
         wr_cnt_en = 1'b0;
         advance   = 1'b0;
      end else if (emit_want) begin
         qwr.push          = pend_v_ff;
         pend_v_in         = 1'b1;
         pend_in.button    = idx_ff;
         pend_in.kind      = emit_kind;
         pend_in.last      = 1'b0;
      end

      if (advance) begin
         if (last_btn) begin
            state_in = ST_FLUSH;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
         end
      end
   end

   // Sequencer state and held word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         pend_v_ff <= pend_v_in;
      end
      levels_ff <= levels_in;
      class_ff  <= class_in;
      pend_ff   <= pend_in;
   end

   // Per-button timers and press counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bcc_pkg::NUM_BUTTONS; i++) begin
            timer_left_ff[i] <= '0;
            timer_run_ff[i]  <= 1'b0;
            press_cnt_ff[i]  <= '0;
         end
      end else begin
         if (wr_en) begin
            timer_left_ff[wr_idx] <= wr_left;
            timer_run_ff[wr_idx]  <= wr_run;
         end
         if (wr_cnt_en) begin
            press_cnt_ff[wr_idx] <= wr_cnt;
         end
      end
   end

endmodule

>>> hw/rtl/bcc_queue.sv
module bcc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bcc_pkg::qwr_type     qwr,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output bcc_pkg::event_type   rd_word
);

   bcc_pkg::event_type           mem_ff [bcc_pkg::QUEUE_DEPTH];
   logic [bcc_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [bcc_pkg::QCNT_W-1:0]   count_ff;
   logic                         do_push, do_pop;

   assign full    = (count_ff == bcc_pkg::QCNT_W'(bcc_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = qwr.push && !full;
   assign do_pop  = pop && !empty;
   assign rd_word = mem_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= qwr.word;
      end
   end

endmodule

>>> hw/rtl/bcc_back.sv
module bcc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  bcc_pkg::event_type   q_word,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bcc_pkg::event_type   out_word
);

   logic                 valid_ff, valid_in;
   bcc_pkg::event_type   word_ff, word_in;

   // Refill the output register when it is empty or being taken
   always_comb begin
      q_pop    = !q_empty && (!valid_ff || out_ready);
      valid_in = valid_ff;
      word_in  = word_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         word_in  = q_word;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/button_click_classifier.sv
// Edge word: taken in its accept cycle; the next word can follow on the very next cycle.
// Tick word: accepted in idle, then a scan of the NUM_BUTTONS timers, one per cycle unless
// a full event queue holds it, a class step per released button while events are enabled and
// a closing flush step. An event word waits in the front until the next event pushes it, or the
// closing step pushes it with its last flag set; it then reaches rsp via the event queue and
// the output register. Sync high reset: timers off, counts and control regs reset.
module button_click_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bcc_pkg::REQ_DATA_W-1:0]       req_tdata,  // [2:0] button_id, [10:3] levels
   input  logic                                 req_tuser,  // [0] opcode
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bcc_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [2:0] event_button
   output logic [2:0]                           rsp_tuser,  // [2:0] event_kind
   output logic                                 rsp_tlast,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]       csr_data
);

   bcc_pkg::cfg_type     cfg_ff;
   bcc_pkg::qwr_type     qwr;
   bcc_pkg::event_type   q_word, out_word;
   logic                 q_full, q_empty, q_pop;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ticks <= bcc_pkg::TIMER_W'(20);
         cfg_ff.long_count     <= bcc_pkg::CNT_W'(50);
         cfg_ff.longlong_count <= bcc_pkg::CNT_W'(150);
         cfg_ff.events_enable  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcc_pkg::REG_INTERVAL: cfg_ff.interval_ticks <= csr_data[bcc_pkg::TIMER_W-1:0];
            bcc_pkg::REG_LONG:     cfg_ff.long_count     <= csr_data[bcc_pkg::CNT_W-1:0];
            bcc_pkg::REG_LONGLONG: cfg_ff.longlong_count <= csr_data[bcc_pkg::CNT_W-1:0];
            bcc_pkg::REG_ENABLE:   cfg_ff.events_enable  <= csr_data[0];
            default: ;
         endcase
      end
   end

   bcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (bcc_pkg::op_type'(req_tuser)),
      .req_id     (req_tdata[bcc_pkg::BTN_W-1:0]),
      .req_levels (req_tdata[bcc_pkg::BTN_W +: bcc_pkg::LEVELS_W]),
      .qwr        (qwr),
      .q_full     (q_full)
   );

   bcc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .qwr     (qwr),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_word (q_word)
   );

   bcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = bcc_pkg::RSP_DATA_W'(out_word.button);
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;

endmodule

>>> hw/rtl/bcc_checker.sv
module bcc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [bcc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [2:0]                      rsp_tuser,
   input  logic                            rsp_tlast
);

   // A stalled response word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // After an edge word is taken, the block is ready again in the next cycle
   a_edge_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bcc_pkg::OP_EDGE) |=> req_tready)
      else $error("not ready after edge word");

   // A tick starts a scan that blocks further requests
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bcc_pkg::OP_TICK) |=> !req_tready)
      else $error("ready during tick scan");

   // Only defined event kinds leave the block
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= 3'(bcc_pkg::KIND_LONGLONG)))
      else $error("undefined event kind");

   // No response in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
